### src/lzss_window_decompressor_top_defines.svh
// Assertion macros used by the LZSS window decompressor parser, lzwd_ctrl.
// Needs nothing else; include by bare file name after the module header.
`ifndef LZSS_WINDOW_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZSS_WINDOW_DECOMPRESSOR_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define LZWD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzwd: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define LZWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzwd: next-cycle check failed");

`endif

### src/lzwd_pkg.sv
// Package for the LZSS window decompressor: beat and register types, CSR indexes.
// No dependencies.
`default_nettype none
package lzwd_pkg;

   localparam int BYTE_W   = 8;
   localparam int POS_W    = 12;
   localparam int LEN_W    = 4;
   localparam int COUNT_W  = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int RUN_W    = 5;   // token length field plus bias, at most 30

   localparam logic [CSR_IDX_W-1:0] CSR_START_POSITION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_BIAS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LIMIT   = 2'd2;

   localparam logic [POS_W-1:0]   START_POSITION_RESET = 12'd4078;
   localparam logic [LEN_W-1:0]   RUN_BIAS_RESET       = 4'd3;
   localparam logic [COUNT_W-1:0] OUTPUT_LIMIT_RESET   = 24'hFFFFFF;

   localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [POS_W-1:0]   start_position;
      logic [LEN_W-1:0]   run_bias;
      logic [COUNT_W-1:0] output_limit;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              run_end;
      logic              limit_reached;
   } beat_type;

endpackage
`default_nettype wire

### src/lzwd_ram.sv
// Generic single-clock RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/lzwd_ctrl.sv
// Token parser and copy sequencer of the LZSS window decompressor.
// Uses lzwd_pkg and drives the window RAM ports; assertion macros from the defines header.
`default_nettype none
module lzwd_ctrl
   import lzwd_pkg::*;
#(
   parameter int WINDOW_SIZE = 4096
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cfg_type                        cfg,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [BYTE_W-1:0]              in_byte,
   input  wire logic                           in_last,
   input  wire logic                           out_free,
   output beat_type                            out_beat,
   output logic                                mem_we,
   output logic [$clog2(WINDOW_SIZE)-1:0]      mem_waddr,
   output logic [BYTE_W-1:0]                   mem_wdata,
   output logic                                mem_re,
   output logic [$clog2(WINDOW_SIZE)-1:0]      mem_raddr,
   input  wire logic [BYTE_W-1:0]              mem_rdata
);
`include "lzss_window_decompressor_top_defines.svh"

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam logic [AW:0] FILL_FULL = (AW+1)'(WINDOW_SIZE);

   typedef enum logic [1:0] {ST_IDLE, ST_COPY_RD, ST_COPY_WR} state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [AW:0]        fill_ff, fill_in;
   logic [BYTE_W-1:0]  flags_ff, flags_in;
   logic [3:0]         left_ff, left_in;
   logic [BYTE_W-1:0]  low_ff, low_in;
   logic               await_ff, await_in;
   logic [COUNT_W-1:0] emitted_ff, emitted_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [RUN_W-1:0]   cnt_ff, cnt_in;
   logic               last_ff, last_in;

   logic               active;
   logic               literal_next;
   logic               fire;
   logic               do_init;
   logic [COUNT_W-1:0] emitted_plus;
   logic [COUNT_W-1:0] room;
   logic [RUN_W-1:0]   tok_len;
   logic [RUN_W-1:0]   run_len;
   logic [AW-1:0]      rel;
   logic               entry_valid;

   assign active       = emitted_ff < cfg.output_limit;
   assign literal_next = active && (left_ff != 4'd0) && !await_ff && flags_ff[0];
   assign in_ready     = (state_ff == ST_IDLE) && (!literal_next || out_free);
   assign fire         = in_valid && in_ready;
   assign emitted_plus = emitted_ff + 24'd1;
   assign room         = cfg.output_limit - emitted_ff;
   assign tok_len      = {1'b0, in_byte[3:0]} + {1'b0, cfg.run_bias};
   assign run_len      = (COUNT_W'(tok_len) > room) ? room[RUN_W-1:0] : tok_len;
   assign rel          = pos_ff - base_ff;
   // entries outside the written run of this stream still read as zero
   assign entry_valid  = {1'b0, rel} < fill_ff;

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      base_in    = base_ff;
      fill_in    = fill_ff;
      flags_in   = flags_ff;
      left_in    = left_ff;
      low_in     = low_ff;
      await_in   = await_ff;
      emitted_in = emitted_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      do_init    = 1'b0;
      out_beat   = '0;
      mem_we     = 1'b0;
      mem_waddr  = wp_ff;
      mem_wdata  = in_byte;
      mem_re     = 1'b0;
      mem_raddr  = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               do_init = in_last;
               if (active) begin
                  if (left_ff == 4'd0) begin
                     flags_in = in_byte;
                     left_in  = FLAGS_PER_BYTE;
                  end else if (await_ff) begin
                     await_in = 1'b0;
                     flags_in = flags_ff >> 1;
                     left_in  = left_ff - 4'd1;
                     if (run_len != '0) begin
                        pos_in   = AW'({in_byte[7:4], low_ff});
                        cnt_in   = run_len;
                        last_in  = in_last;
                        state_in = ST_COPY_RD;
                        do_init  = 1'b0;   // defer until the copy is out
                     end
                  end else if (flags_ff[0]) begin
                     mem_we                 = 1'b1;
                     out_beat.valid         = 1'b1;
                     out_beat.data          = in_byte;
                     out_beat.run_end       = 1'b1;
                     out_beat.limit_reached = emitted_plus == cfg.output_limit;
                     wp_in      = wp_ff + 1'b1;
                     fill_in    = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;
                     emitted_in = emitted_plus;
                     flags_in   = flags_ff >> 1;
                     left_in    = left_ff - 4'd1;
                  end else begin
                     low_in   = in_byte;
                     await_in = 1'b1;
                  end
               end
            end
         end
         ST_COPY_RD: begin
            if (out_free) begin
               mem_re   = 1'b1;
               state_in = ST_COPY_WR;
            end
         end
         ST_COPY_WR: begin
            mem_we                 = 1'b1;
            mem_wdata              = entry_valid ? mem_rdata : '0;
            out_beat.valid         = 1'b1;
            out_beat.data          = mem_wdata;
            out_beat.run_end       = cnt_ff == RUN_W'(1);
            out_beat.limit_reached = emitted_plus == cfg.output_limit;
            wp_in      = wp_ff + 1'b1;
            fill_in    = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;
            emitted_in = emitted_plus;
            pos_in     = pos_ff + 1'b1;
            cnt_in     = cnt_ff - RUN_W'(1);
            if (cnt_ff == RUN_W'(1)) begin
               state_in = ST_IDLE;
               do_init  = last_ff;
            end else begin
               state_in = ST_COPY_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (do_init) begin
         wp_in      = AW'(cfg.start_position);
         base_in    = AW'(cfg.start_position);
         fill_in    = '0;
         flags_in   = '0;
         left_in    = '0;
         low_in     = '0;
         await_in   = 1'b0;
         emitted_in = '0;
         last_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wp_ff      <= AW'(START_POSITION_RESET);
         base_ff    <= AW'(START_POSITION_RESET);
         fill_ff    <= '0;
         flags_ff   <= '0;
         left_ff    <= '0;
         low_ff     <= '0;
         await_ff   <= 1'b0;
         emitted_ff <= '0;
         cnt_ff     <= '0;
         last_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         base_ff    <= base_in;
         fill_ff    <= fill_in;
         flags_ff   <= flags_in;
         left_ff    <= left_in;
         low_ff     <= low_in;
         await_ff   <= await_in;
         emitted_ff <= emitted_in;
         cnt_ff     <= cnt_in;
         last_ff    <= last_in;
      end
      pos_ff <= pos_in;
   end

   `LZWD_ASSERT_NEXT(a_rd_then_wr, clock, reset,
                     (state_ff == ST_COPY_RD) && out_free, state_ff == ST_COPY_WR)
   `LZWD_ASSERT_IMPL(a_beat_has_room, clock, reset, out_beat.valid, out_free)
   `LZWD_ASSERT_IMPL(a_copy_count, clock, reset, state_ff != ST_IDLE, cnt_ff != '0)
   `LZWD_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_FULL)

endmodule
`default_nettype wire

### src/lzss_window_decompressor_top.sv
// LZSS window decompressor top level: CSR bank, result register, parser and window RAM.
// Uses lzwd_pkg, lzwd_ctrl and lzwd_ram.
//
// Usage:
//  - req_ carries compressed bytes, one per beat; req_tlast marks a stream's last byte.
//  - rsp_ carries decoded bytes; rsp_tlast ends the run caused by one input beat and
//    rsp_tuser flags that the stream's decoded count has reached output_limit.
//  - csr_ writes start_position (0), run_bias (1) and output_limit (2); it is
//    always ready. Write only while the block is idle.
// Timing:
//  - Flag bytes and token low bytes produce nothing.
//  - A literal shows on rsp_ in the cycle after it is accepted.
//  - A token high byte starting a copy of L bytes keeps req_ closed until the copy
//    is done: each copied byte is one window read, then one window write plus a
//    result beat, since the window RAM's read port is registered.
// Reset and stream end:
//  - Reset restores the register defaults and empties the window. No clearing pass is
//    run: a fill count of bytes written since stream start marks which entries are
//    live, and the rest read as zero. Every req_tlast beat empties the window so too.
// Stall:
//  - A held rsp_ beat blocks the next literal or copy byte; other bytes still flow.
`default_nettype none
module lzss_window_decompressor_top
   import lzwd_pkg::*;
#(
   parameter int WINDOW_SIZE = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] in_byte
   input  wire logic                  req_tlast,   // in_last
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] out_byte
   output logic                       rsp_tlast,   // run_end
   output logic                       rsp_tuser,   // [0] limit_reached
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(WINDOW_SIZE);

   cfg_type           cfg_ff;
   beat_type          beat;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;
   logic              rsp_user_ff;
   logic              out_free;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [BYTE_W-1:0] mem_rdata;

   assign csr_ready = 1'b1;

   // Register bank; an index past the list is taken and dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_position <= START_POSITION_RESET;
         cfg_ff.run_bias       <= RUN_BIAS_RESET;
         cfg_ff.output_limit   <= OUTPUT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_POSITION: cfg_ff.start_position <= csr_data[POS_W-1:0];
            CSR_RUN_BIAS:       cfg_ff.run_bias       <= csr_data[LEN_W-1:0];
            CSR_OUTPUT_LIMIT:   cfg_ff.output_limit   <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Result register: free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (beat.valid) begin
         rsp_data_ff <= beat.data;
         rsp_last_ff <= beat.run_end;
         rsp_user_ff <= beat.limit_reached;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   lzwd_ctrl #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .out_free  (out_free),
      .out_beat  (beat),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   lzwd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_SIZE)
   ) u_window (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for lzss_window_decompressor_top: drives compressed streams,
// predicts every decoded byte from its own window model and checks the rsp_ beats.
// Depends on lzwd_pkg and the lzss_window_decompressor_top RTL.
module tb_top
   import lzwd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 5000;  // cycles with no beat on any channel
   localparam int SETTLE_CYCLES = 80;    // longest copy is 30 bytes
   localparam int MAX_REPORTS   = 10;
   localparam int PHASE_ITEMS   = 65;
   localparam int HIST_DEPTH    = 4096;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;  // unmapped index, must be ignored

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } comp_byte_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              run_end;
      logic              limit_reached;
   } plain_byte_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Stimulus waiting for the driver, decoded bytes waiting for the DUT.
   comp_byte_type  pend_q[$];
   plain_byte_type decoded_q[$];

   // Own copy of the decompressor state and its registers.
   logic [BYTE_W-1:0]  hist_mem [HIST_DEPTH];
   logic [POS_W-1:0]   wr_pos;
   logic [BYTE_W-1:0]  flag_reg;
   logic [3:0]         flags_left;
   logic [BYTE_W-1:0]  low_hold;
   logic               want_high;
   logic [COUNT_W-1:0] emitted_cnt;
   logic [POS_W-1:0]   cfg_start;
   logic [LEN_W-1:0]   cfg_offset;
   logic [COUNT_W-1:0] cfg_limit;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int          mismatch_cnt = 0;
   int          quiet_cnt = 0;
   logic        req_took;
   logic        csr_took;
   comp_byte_type nxt_byte;

   lzss_window_decompressor_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   // Empty the window and rewind the parser, as after reset or a stream's last byte.
   function automatic void restart_stream();
      for (int i = 0; i < HIST_DEPTH; i++)
         hist_mem[i] = '0;
      wr_pos      = cfg_start;
      flag_reg    = '0;
      flags_left  = '0;
      low_hold    = '0;
      want_high   = 1'b0;
      emitted_cnt = '0;
   endfunction

   function automatic void consume_flag();
      flag_reg = flag_reg >> 1;
      if (flags_left != 0)
         flags_left = flags_left - 1'b1;
   endfunction

   // Emit one decoded byte: write it into the window and queue the beat it must show as.
   function automatic void emit_plain(logic [BYTE_W-1:0] v);
      hist_mem[wr_pos] = v;
      wr_pos      = wr_pos + 1'b1;
      emitted_cnt = emitted_cnt + 1'b1;
      decoded_q.push_back('{data: v, run_end: 1'b0,
                            limit_reached: (emitted_cnt == cfg_limit)});
   endfunction

   // Work out the decoded bytes that one compressed byte causes.
   function automatic void lzss_decode_byte(logic [BYTE_W-1:0] b, logic last);
      logic [POS_W-1:0]   src;
      logic [RUN_W-1:0]   run;
      logic [COUNT_W-1:0] room;
      int                 produced;
      produced = 0;
      if (emitted_cnt < cfg_limit) begin
         if (flags_left == 0) begin
            flag_reg   = b;
            flags_left = FLAGS_PER_BYTE;
         end else if (want_high) begin
            src  = {b[7:4], low_hold};
            run  = RUN_W'(b[3:0]) + RUN_W'(cfg_offset);
            room = cfg_limit - emitted_cnt;
            if (COUNT_W'(run) > room)
               run = RUN_W'(room);
            // byte by byte, so a copy may read what it has just written
            for (int j = 0; j < int'(run); j++) begin
               emit_plain(hist_mem[src]);
               src = src + 1'b1;
            end
            produced  = int'(run);
            want_high = 1'b0;
            consume_flag();
         end else if (flag_reg[0]) begin
            emit_plain(b);
            produced = 1;
            consume_flag();
         end else begin
            low_hold  = b;
            want_high = 1'b1;
         end
      end
      if (produced > 0)
         decoded_q[decoded_q.size()-1].run_end = 1'b1;
      if (last)
         restart_stream();
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_START_POSITION: cfg_start  = d[POS_W-1:0];
         CSR_RUN_BIAS:       cfg_offset = d[LEN_W-1:0];
         CSR_OUTPUT_LIMIT:   cfg_limit  = d[COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void report_mismatch(string what, plain_byte_type e, plain_byte_type a);
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
         $display("%0t: %s: expected byte %02h end %0b limit %0b, got %02h end %0b limit %0b",
                  $realtime, what, e.data, e.run_end, e.limit_reached,
                  a.data, a.run_end, a.limit_reached);
   endfunction

   // ------------------------------------------------------------------- driver

   // Change inputs on the falling edge; hold a req_ beat until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (!req_tvalid || req_took) begin
            if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt_byte = pend_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt_byte.data;
               req_tlast  <= nxt_byte.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------ monitor

   // Sample on the rising edge: apply register writes, predict on every accepted
   // req_ beat, then check every accepted rsp_ beat against the oldest prediction.
   always @(posedge clock) begin
      plain_byte_type got;
      plain_byte_type want;
      if (reset) begin
         req_took <= 1'b0;
         csr_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         csr_took <= csr_valid && csr_ready;
         if (csr_valid && csr_ready)
            apply_csr(csr_index, csr_data);
         if (req_tvalid && req_tready)
            lzss_decode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = '{data: rsp_tdata, run_end: rsp_tlast, limit_reached: rsp_tuser};
            if (decoded_q.size() == 0) begin
               report_mismatch("unexpected beat", '0, got);
            end else begin
               want = decoded_q.pop_front();
               if (got != want)
                  report_mismatch("wrong beat", want, got);
            end
         end
         // watchdog: any beat on any channel counts as progress
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cnt = 0;
         else
            quiet_cnt++;
         if (quiet_cnt == QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
            $display("** lzss_window_decompressor_top: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic queue_byte(logic [7:0] b, logic last);
      pend_q.push_back('{data: b, last: last});
   endtask

   // Hold the sender until the block has drained: nothing queued, nothing pending, no
   // decoded byte still expected, then let trailing flag and low bytes finish.
   task automatic wait_drained();
      while (pend_q.size() != 0 || req_tvalid)
         @(posedge clock);
      while (decoded_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do
         @(negedge clock);
      while (!csr_took);
      csr_valid <= 1'b0;
   endtask

   // Queue one stream of flag groups with random literals and tokens; a clean one is well-formed.
   // Tokens mostly point back into bytes already decoded, often overlapping their own
   // output. A broken stream is cut at a random byte, which may split a token.
   task automatic queue_stream(int groups, bit clean, output int count);
      comp_byte_type     seq[$];
      logic [7:0]        flags;
      logic [POS_W-1:0]  src;
      logic [3:0]        len_f;
      int                decoded;
      int unsigned       back_dist;
      int unsigned       cut;
      decoded = 0;
      for (int g = 0; g < groups; g++) begin
         flags = 8'($urandom);
         seq.push_back('{data: flags, last: 1'b0});
         for (int k = 0; k < 8; k++) begin
            if (flags[k]) begin
               seq.push_back('{data: 8'($urandom), last: 1'b0});
               decoded++;
            end else begin
               len_f = 4'($urandom);
               if (decoded > 0 && $urandom_range(0, 3) != 0) begin
                  back_dist = $urandom_range(1, (decoded < 40) ? decoded : 40);
                  src  = POS_W'(int'(cfg_start) + decoded - int'(back_dist));
               end else begin
                  src = POS_W'($urandom);
               end
               seq.push_back('{data: src[7:0], last: 1'b0});
               seq.push_back('{data: {src[11:8], len_f}, last: 1'b0});
               decoded += int'(len_f) + int'(cfg_offset);
            end
         end
      end
      if (!clean) begin
         cut = $urandom_range(1, seq.size());
         while (seq.size() > cut)
            void'(seq.pop_back());
      end
      seq[seq.size()-1].last = 1'b1;
      foreach (seq[i])
         pend_q.push_back(seq[i]);
      count = seq.size();
   endtask

   initial begin
      int n;
      int phase_items;
      int unsigned noise_len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      send_idle_pct = 34;
      recv_idle_pct = 70;
      cfg_start  = START_POSITION_RESET;
      cfg_offset = RUN_BIAS_RESET;
      cfg_limit  = OUTPUT_LIMIT_RESET;
      restart_stream();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register defaults: literal, a token copying over its own output, a token
      // reading never-written (zero) entries across the wrap, literal ending the stream.
      queue_byte(8'h55, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hEE, 1'b0);
      queue_byte(8'hF0, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h0F, 1'b0);
      queue_byte(8'hA5, 1'b1);
      wait_drained();

      // Zero limit: the whole stream decodes to nothing.
      csr_write(CSR_OUTPUT_LIMIT, '0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h42, 1'b1);
      wait_drained();

      // Window start at the top entry, zero run bias, limit of four: a zero-length
      // token, a literal, a copy cut at the limit, then bytes ignored past the limit.
      csr_write(CSR_START_POSITION, 24'd4095);
      csr_write(CSR_RUN_BIAS, '0);
      csr_write(CSR_OUTPUT_LIMIT, 24'd4);
      queue_byte(8'h02, 1'b1);   // restart so the new start position takes hold
      queue_byte(8'h02, 1'b0);
      queue_byte(8'h10, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h9C, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFE, 1'b0);
      queue_byte(8'h77, 1'b0);
      queue_byte(8'h88, 1'b1);
      wait_drained();

      // Limit lowered to the count already decoded mid-stream; start position moved
      // mid-stream only applies from the next stream on.
      csr_write(CSR_RUN_BIAS, 24'd15);
      csr_write(CSR_OUTPUT_LIMIT, 24'hFFFFFF);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h80, 1'b0);
      wait_drained();
      csr_write(CSR_OUTPUT_LIMIT, COUNT_W'(emitted_cnt));
      csr_write(CSR_START_POSITION, '0);
      queue_byte(8'h33, 1'b0);
      queue_byte(8'h44, 1'b1);
      wait_drained();
      csr_write(CSR_OUTPUT_LIMIT, 24'hFFFFFF);
      // token cut off by the stream end, then a stream of just a flag byte
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h01, 1'b1);
      queue_byte(8'hC3, 1'b1);
      wait_drained();

      // Random part in three idling phases, each with fresh register settings.
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 34; recv_idle_pct = 70; end
            1: begin send_idle_pct = 70; recv_idle_pct = 34; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         wait_drained();
         csr_write(CSR_START_POSITION, CSR_DATA_W'($urandom_range(0, 4095)));
         csr_write(CSR_RUN_BIAS, CSR_DATA_W'($urandom_range(0, 15)));
         if ($urandom_range(0, 2) == 0)
            csr_write(CSR_OUTPUT_LIMIT, CSR_DATA_W'($urandom_range(1, 120)));
         else
            csr_write(CSR_OUTPUT_LIMIT, 24'hFFFFFF);
         csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
         // flush any half-finished stream so generation starts from a clean state
         queue_byte(8'h00, 1'b1);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: raw bytes, always closed by a last byte
               noise_len = $urandom_range(1, 6);
               for (int i = 0; i < int'(noise_len); i++)
                  queue_byte(8'($urandom), (i == int'(noise_len) - 1));
               n = int'(noise_len);
            end else begin
               queue_stream($urandom_range(1, 3), ($urandom_range(0, 4) != 0), n);
            end
            phase_items += n;
         end
      end

      wait_drained();
      if (mismatch_cnt == 0 && decoded_q.size() == 0)
         $display("** lzss_window_decompressor_top: PASSED **");
      else
         $display("** lzss_window_decompressor_top: FAILED **");
      $finish;
   end

endmodule
